[design/mvn_pkg.sv]
// shared types and constants for the mesh vertex normal engine
// no dependencies; imported by mvn_norm and the top module
package mvn_pkg;

  localparam int MVN_MAX_VERTICES = 1024;
  localparam int MVN_COORD_WIDTH  = 16;
  localparam int MVN_SUM_WIDTH    = 24;
  // cross product components need 35 signed bits
  localparam int MVN_VEC_W_MIN    = 35;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FACE = 2'd1,
    OP_READ = 2'd2
  } opcode_t;

  localparam logic KIND_FACE   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_FRDA,
    S_FRDB,
    S_FRDC,
    S_FCAP,
    S_MUL,
    S_VRD,
    S_VCAP,
    S_NSTART,
    S_NORM,
    S_OUT,
    S_ACRD,
    S_ACWR
  } top_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DIVLD,
    N_DIV,
    N_DONE
  } norm_state_t;

endpackage

[design/mvn_ram.sv]
// simple dual-port synchronous ram, one write and one registered read port
// depends on nothing but its parameters
module mvn_ram #(
  parameter int DATA_W = 48,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/mvn_norm.sv]
// vector normalizer: block-float shift, sum of squares, bit-serial square root,
// restoring divide per component; uses mvn_pkg
module mvn_norm #(
  parameter int VEC_W = mvn_pkg::MVN_VEC_W_MIN
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2:0][VEC_W-1:0] vec,
  output logic                  done,
  output logic                  deg,
  output logic [2:0][15:0]      nrm
);
  import mvn_pkg::*;

  localparam logic [VEC_W-1:0] M_LO = VEC_W'(1 << 29);
  localparam logic [VEC_W-1:0] M_HI = VEC_W'(1 << 30);

  norm_state_t state_r, state_nxt;

  logic [2:0][VEC_W-1:0] a_r;
  logic [2:0]            neg_r;
  logic [VEC_W-1:0]      m_r;
  logic                  deg_r;
  logic [1:0]            cnt_r;
  logic [59:0]           prod_r;
  logic [63:0]           sq_r;
  logic [63:0]           x_r;
  logic [63:0]           root_r;
  logic [4:0]            k_r;
  logic [46:0]           rem_r;
  logic [3:0]            qb_r;
  logic [14:0]           q_r;
  logic [2:0][15:0]      n_r;

  logic [2:0][VEC_W-1:0] mag_in;
  logic [VEC_W-1:0]      max01, max_in;
  logic [29:0]           a_sel;
  logic [63:0]           bitv, trial;
  logic [46:0]           dsh;
  logic                  fits;
  logic [14:0]           q_nxt;
  logic [15:0]           qv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = vec[i][VEC_W-1] ? (~vec[i] + VEC_W'(1)) : vec[i];
    end
    max01  = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
    max_in = (max01 > mag_in[2]) ? max01 : mag_in[2];
  end

  always_comb begin
    unique case (cnt_r)
      2'd0:    a_sel = a_r[0][29:0];
      2'd1:    a_sel = a_r[1][29:0];
      default: a_sel = a_r[2][29:0];
    endcase
  end

  // one root bit per cycle, bit weight 4^k
  assign bitv  = 64'(1) << {k_r, 1'b0};
  assign trial = root_r + bitv;
  // divisor is twice the length
  assign dsh   = (47'(root_r[31:0]) << 1) << qb_r;
  assign fits  = rem_r >= dsh;

  always_comb begin
    q_nxt = q_r;
    q_nxt[qb_r] = fits;
  end

  assign qv = {1'b0, q_nxt};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      N_IDLE:  if (start) state_nxt = (max_in == '0) ? N_DONE : N_SHIFT;
      N_SHIFT: if (m_r >= M_LO && m_r < M_HI) state_nxt = N_SQ;
      N_SQ:    if (cnt_r == 2'd3) state_nxt = N_SQRT;
      N_SQRT:  if (k_r == '0) state_nxt = N_DIVLD;
      N_DIVLD: state_nxt = N_DIV;
      N_DIV: begin
        if (qb_r == '0) state_nxt = (cnt_r == 2'd2) ? N_DONE : N_DIVLD;
      end
      N_DONE:  state_nxt = N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == N_DONE);
    deg  = deg_r;
    nrm  = n_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      N_IDLE: begin
        if (start) begin
          a_r   <= mag_in;
          m_r   <= max_in;
          neg_r <= {vec[2][VEC_W-1], vec[1][VEC_W-1], vec[0][VEC_W-1]};
          deg_r <= (max_in == '0);
          n_r   <= '0;
        end
      end
      N_SHIFT: begin
        if (m_r < M_LO) begin
          m_r <= m_r << 1;
          for (int i = 0; i < 3; i++) a_r[i] <= a_r[i] << 1;
        end else if (m_r >= M_HI) begin
          m_r <= m_r >> 1;
          for (int i = 0; i < 3; i++) a_r[i] <= a_r[i] >> 1;
        end else begin
          cnt_r <= '0;
          sq_r  <= '0;
        end
      end
      N_SQ: begin
        prod_r <= 60'(a_sel) * 60'(a_sel);
        if (cnt_r != 2'd0) sq_r <= sq_r + 64'(prod_r);
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          x_r    <= sq_r + 64'(prod_r);
          root_r <= '0;
          k_r    <= 5'd31;
        end
      end
      N_SQRT: begin
        if (x_r >= trial) begin
          x_r    <= x_r - trial;
          root_r <= (root_r >> 1) + bitv;
        end else begin
          root_r <= root_r >> 1;
        end
        k_r   <= k_r - 5'd1;
        cnt_r <= '0;
      end
      N_DIVLD: begin
        // |c| * 32768 + len, rounds half up after divide by 2 * len
        rem_r <= {2'b00, a_sel, 15'd0} + 47'(root_r[31:0]);
        qb_r  <= 4'd14;
        q_r   <= '0;
      end
      N_DIV: begin
        if (fits) rem_r <= rem_r - dsh;
        q_r  <= q_nxt;
        qb_r <= qb_r - 4'd1;
        if (qb_r == '0) begin
          n_r[cnt_r] <= neg_r[cnt_r] ? (~qv + 16'd1) : qv;
          cnt_r <= cnt_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[design/mesh_vertex_normal_engine_top.sv]
// Mesh vertex normal engine. Vertex positions and per-vertex normal sums live in
// two rams with registered read ports; a face reads its three corners one after
// another, builds the cross product on one shared 17x17 multiplier, hands it to the
// normalizer and then, unless it is degenerate, updates the three corner sums one
// read-modify-write at a time. Items are processed one at a time, their duration set
// mostly by the normalizer's shift, square root and per-component divide steps,
// which a degenerate face or a zero sum skips. A result waiting in the output
// register does not stop the next item from being accepted. Sums of vertices never
// loaded read as garbage.
// uses mvn_pkg, mvn_ram and mvn_norm
module mesh_vertex_normal_engine_top #(
  parameter int MAX_VERTICES = mvn_pkg::MVN_MAX_VERTICES,
  parameter int COORD_WIDTH  = mvn_pkg::MVN_COORD_WIDTH,
  parameter int SUM_WIDTH    = mvn_pkg::MVN_SUM_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // vertex_index, pos_x_in, pos_y_in, pos_z_in, corner_a, corner_b, corner_c
  input  logic [87:0] in_tdata,
  // opcode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // normal_x, normal_y, normal_z
  output logic [47:0] out_tdata,
  // result_kind, degenerate
  output logic [1:0]  out_tuser
);
  import mvn_pkg::*;

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CWE = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
  localparam int SW  = SUM_WIDTH;
  localparam int VW  = (SUM_WIDTH > MVN_VEC_W_MIN) ? SUM_WIDTH : MVN_VEC_W_MIN;

  function automatic logic [AW-1:0] idx_mod(input logic [9:0] v);
    logic [9:0] r;
    r = v;
    for (int k = 9; k >= 0; k--) begin
      if ({22'd0, r} >= (32'(MAX_VERTICES) << k)) r = r - 10'(32'(MAX_VERTICES) << k);
    end
    return AW'(r);
  endfunction

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s, input logic [15:0] n);
    logic [SW:0] t;
    t = {s[SW-1], s} + (SW+1)'($signed(n));
    if (t[SW] != t[SW-1]) begin
      return t[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    return t[SW-1:0];
  endfunction

  top_state_t state_r, state_nxt;

  logic [1:0]             op_r;
  logic [AW-1:0]          idx_r, ca_r, cb_r, cc_r;
  logic [3*CWE-1:0]       pos_r;
  logic [2:0][16:0]       pa_r, pb_r, pc, e1_r, e2_r;
  logic signed [16:0]     op_a, op_b;
  logic signed [33:0]     prod_r;
  logic [2:0]             mcnt_r, mstep;
  logic [1:0]             kc_r;
  logic [2:0][VW-1:0]     vec_r;
  logic                   out_valid_r;
  logic [47:0]            out_data_r;
  logic [1:0]             out_user_r;
  logic                   out_free;

  logic                   pos_we, sum_we;
  logic [AW-1:0]          pos_raddr, sum_raddr, sum_waddr;
  logic [3*CWE-1:0]       pos_rdata;
  logic [3*SW-1:0]        sum_rdata, sum_wdata;
  logic                   norm_start, norm_done, norm_deg;
  logic [2:0][15:0]       norm_n;
  logic [AW-1:0]          corner_k;

  mvn_ram #(.DATA_W(3*CWE), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk  (clk),
    .we   (pos_we),
    .waddr(idx_r),
    .wdata(pos_r),
    .raddr(pos_raddr),
    .rdata(pos_rdata)
  );

  mvn_ram #(.DATA_W(3*SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk  (clk),
    .we   (sum_we),
    .waddr(sum_waddr),
    .wdata(sum_wdata),
    .raddr(sum_raddr),
    .rdata(sum_rdata)
  );

  mvn_norm #(.VEC_W(VW)) u_norm (
    .clk  (clk),
    .rst_n(rst_n),
    .start(norm_start),
    .vec  (vec_r),
    .done (norm_done),
    .deg  (norm_deg),
    .nrm  (norm_n)
  );

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    unique case (kc_r)
      2'd0:    corner_k = ca_r;
      2'd1:    corner_k = cb_r;
      default: corner_k = cc_r;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pc[i] = 17'($signed(pos_rdata[i*CWE +: CWE]));
    end
  end

  // cross product terms in the order y*z, z*y, z*x, x*z, x*y, y*x
  always_comb begin
    unique case (mcnt_r)
      3'd0:    begin op_a = e1_r[1]; op_b = e2_r[2]; end
      3'd1:    begin op_a = e1_r[2]; op_b = e2_r[1]; end
      3'd2:    begin op_a = e1_r[2]; op_b = e2_r[0]; end
      3'd3:    begin op_a = e1_r[0]; op_b = e2_r[2]; end
      3'd4:    begin op_a = e1_r[0]; op_b = e2_r[1]; end
      default: begin op_a = e1_r[1]; op_b = e2_r[0]; end
    endcase
  end

  assign mstep = mcnt_r - 3'd1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_wdata[i*SW +: SW] = (state_r == S_LOAD) ? '0 :
                              sat_add(sum_rdata[i*SW +: SW], norm_n[i]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tuser)
            OP_LOAD: state_nxt = S_LOAD;
            OP_FACE: state_nxt = S_FRDA;
            OP_READ: state_nxt = S_VRD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD:   state_nxt = S_IDLE;
      S_FRDA:   state_nxt = S_FRDB;
      S_FRDB:   state_nxt = S_FRDC;
      S_FRDC:   state_nxt = S_FCAP;
      S_FCAP:   state_nxt = S_MUL;
      S_MUL:    if (mcnt_r == 3'd6) state_nxt = S_NSTART;
      S_VRD:    state_nxt = S_VCAP;
      S_VCAP:   state_nxt = S_NSTART;
      S_NSTART: state_nxt = S_NORM;
      S_NORM:   if (norm_done) state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = (op_r == OP_FACE && !norm_deg) ? S_ACRD : S_IDLE;
        end
      end
      S_ACRD:   state_nxt = S_ACWR;
      S_ACWR:   state_nxt = (kc_r == 2'd2) ? S_IDLE : S_ACRD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == S_IDLE) && rst_n;
    pos_we     = (state_r == S_LOAD);
    sum_we     = (state_r == S_LOAD) || (state_r == S_ACWR);
    sum_waddr  = (state_r == S_LOAD) ? idx_r : corner_k;
    sum_raddr  = (state_r == S_VRD) ? idx_r : corner_k;
    norm_start = (state_r == S_NSTART);
    unique case (state_r)
      S_FRDA:  pos_raddr = ca_r;
      S_FRDB:  pos_raddr = cb_r;
      default: pos_raddr = cc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= in_tuser;
      idx_r <= idx_mod(in_tdata[9:0]);
      pos_r <= {in_tdata[42 +: CWE], in_tdata[26 +: CWE], in_tdata[10 +: CWE]};
      ca_r  <= idx_mod(in_tdata[67:58]);
      cb_r  <= idx_mod(in_tdata[77:68]);
      cc_r  <= idx_mod(in_tdata[87:78]);
    end
    unique case (state_r)
      S_FRDB: pa_r <= pc;
      S_FRDC: pb_r <= pc;
      S_FCAP: begin
        for (int i = 0; i < 3; i++) begin
          e1_r[i] <= pb_r[i] - pa_r[i];
          e2_r[i] <= pc[i] - pa_r[i];
        end
        mcnt_r <= '0;
      end
      S_MUL: begin
        prod_r <= op_a * op_b;
        if (mcnt_r != 3'd0) begin
          // even step opens a component, odd step subtracts the second term
          vec_r[mstep[2:1]] <= mstep[0] ? (vec_r[mstep[2:1]] - VW'(prod_r)) : VW'(prod_r);
        end
        mcnt_r <= mcnt_r + 3'd1;
      end
      S_VCAP: begin
        for (int i = 0; i < 3; i++) begin
          vec_r[i] <= VW'($signed(sum_rdata[i*SW +: SW]));
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_data_r <= norm_n;
          out_user_r <= {norm_deg, (op_r == OP_FACE) ? KIND_FACE : KIND_VERTEX};
        end
        kc_r <= '0;
      end
      S_ACWR: kc_r <= kc_r + 2'd1;
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_norm_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> state_r == S_NORM)
    else $error("normalizer finished while not awaited");

  a_sum_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    sum_we |-> (state_r == S_LOAD || state_r == S_ACWR))
    else $error("sum ram written outside load or accumulate");

  // an unused opcode is dropped in the accept cycle, so only real work makes it busy
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    (in_tuser == OP_LOAD || in_tuser == OP_FACE || in_tuser == OP_READ) |=> !in_tready)
    else $error("second word accepted while busy");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_valid_r && !out_tready |=> state_r == S_OUT)
    else $error("result dropped while output stalled");
`endif

endmodule
